// File: hw/rtl/kft_pkg.sv
// Shared types and codes for the keyed fingerprint table.
// Holds command and status codes, field widths and the stored entry layout.
// No dependencies.
`timescale 1ns / 1ps

package kft_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 64;
  localparam int FP_W   = 64;
  localparam int TIME_W = 64;
  localparam int HITS_W = 32;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUT        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HIT        = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVALIDATE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [FP_W-1:0]   fp;
    logic [TIME_W-1:0] created;
    logic [HITS_W-1:0] hits;
  } entry_t;

endpackage

// File: hw/rtl/keyed_fingerprint_table_core.sv
// Keyed fingerprint table top level: entry memory, valid bits, key scan and write-back.
// Depends on kft_pkg for codes, widths and the entry layout.
`timescale 1ns / 1ps

// Processes one item at a time. Put and hit scan the occupied slots through the
// single read port of the entry memory, one slot per cycle, and stop at the
// first key match or after the last used slot. Invalidate, a put with a zero
// fingerprint and an unused command skip the scan and go straight to the
// result. The next item is accepted once the result has loaded and the block
// is back in idle. A new item is taken while the previous result still waits
// on out_ready; its result then holds until the output is free. Valid bits
// live in flip-flops and reset clears them at once, so there is no clearing
// pass.
module keyed_fingerprint_table_core #(
  parameter int ENTRIES = kft_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kft_pkg::CMD_W-1:0]   in_command,
  input  logic [kft_pkg::KEY_W-1:0]   in_key,
  input  logic [kft_pkg::FP_W-1:0]    in_fingerprint,
  input  logic [kft_pkg::TIME_W-1:0]  in_created_at,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kft_pkg::STAT_W-1:0]  out_status,
  output logic [kft_pkg::FP_W-1:0]    out_fingerprint_out,
  output logic [kft_pkg::HITS_W-1:0]  out_hit_count
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  kft_pkg::entry_t mem [ENTRIES];
  kft_pkg::entry_t rd_data_r;

  logic [1:0]                 state_r, state_nxt;
  logic [ENTRIES-1:0]         valid_r;
  logic [CNT_W-1:0]           used_r;
  logic [CNT_W-1:0]           issue_r;
  logic                       pend_r;
  logic [IDX_W-1:0]           pend_idx_r;
  logic                       found_r;
  logic [IDX_W-1:0]           hit_idx_r;
  kft_pkg::entry_t            ent_r;

  logic [kft_pkg::CMD_W-1:0]  cmd_r;
  logic [kft_pkg::KEY_W-1:0]  key_r;
  logic [kft_pkg::FP_W-1:0]   fp_r;
  logic [kft_pkg::TIME_W-1:0] time_r;

  logic                        out_valid_r;
  logic [kft_pkg::STAT_W-1:0]  out_status_r;
  logic [kft_pkg::FP_W-1:0]    out_fp_r;
  logic [kft_pkg::HITS_W-1:0]  out_hits_r;

  logic                        accept;
  logic                        rd_en;
  logic                        match;
  logic                        fin_go;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  kft_pkg::entry_t             wr_data;
  logic                        set_valid;
  logic                        clr_all;
  logic                        used_inc;
  logic [kft_pkg::STAT_W-1:0]  res_status;
  logic [kft_pkg::FP_W-1:0]    res_fp;
  logic [kft_pkg::HITS_W-1:0]  res_hits;
  logic [kft_pkg::HITS_W-1:0]  hits_inc;
  logic                        skip_scan;

  assign in_ready            = (state_r == S_IDLE);
  assign accept              = in_valid && in_ready;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_fingerprint_out = out_fp_r;
  assign out_hit_count       = out_hits_r;

  assign skip_scan = !((in_command == kft_pkg::CMD_PUT && in_fingerprint != '0) ||
                       in_command == kft_pkg::CMD_HIT);
  assign rd_en     = (state_r == S_SCAN) && (issue_r < used_r);
  assign match     = pend_r && (rd_data_r.key == key_r);
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign hits_inc  = (ent_r.hits == '1) ? ent_r.hits : ent_r.hits + 32'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = skip_scan ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || (!pend_r && issue_r >= used_r)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx_r;
    wr_data    = ent_r;
    set_valid  = 1'b0;
    clr_all    = 1'b0;
    used_inc   = 1'b0;
    res_status = kft_pkg::ST_OK;
    res_fp     = '0;
    res_hits   = '0;
    unique case (cmd_r)
      kft_pkg::CMD_PUT: begin
        if (fp_r == '0) begin
          res_status = kft_pkg::ST_INVALID;
        end else if (found_r) begin
          wr_en           = 1'b1;
          wr_data.fp      = fp_r;
          wr_data.created = time_r;
          set_valid       = 1'b1;
        end else if (used_r >= CNT_MAX) begin
          res_status = kft_pkg::ST_FULL;
        end else begin
          wr_en           = 1'b1;
          wr_addr         = used_r[IDX_W-1:0];
          wr_data.key     = key_r;
          wr_data.fp      = fp_r;
          wr_data.created = time_r;
          wr_data.hits    = '0;
          set_valid       = 1'b1;
          used_inc        = 1'b1;
        end
      end
      kft_pkg::CMD_HIT: begin
        if (found_r && valid_r[hit_idx_r]) begin
          wr_en        = 1'b1;
          wr_data.hits = hits_inc;
          res_fp       = ent_r.fp;
          res_hits     = hits_inc;
        end else begin
          res_status = kft_pkg::ST_NOT_FOUND;
        end
      end
      kft_pkg::CMD_INVALIDATE: begin
        clr_all = 1'b1;
      end
      default: res_status = kft_pkg::ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_go && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[issue_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      used_r      <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        issue_r <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        pend_r <= rd_en && !match;
        if (rd_en) begin
          issue_r <= issue_r + CNT_W'(1);
        end
        if (match) begin
          found_r <= 1'b1;
        end
      end
      if (fin_go) begin
        if (clr_all) begin
          valid_r <= '0;
        end else if (set_valid) begin
          valid_r[wr_addr] <= 1'b1;
        end
        if (used_inc) begin
          used_r <= used_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      key_r  <= in_key;
      fp_r   <= in_fingerprint;
      time_r <= in_created_at;
    end
    if (rd_en) begin
      pend_idx_r <= issue_r[IDX_W-1:0];
    end
    if (match) begin
      hit_idx_r <= pend_idx_r;
      ent_r     <= rd_data_r;
    end
    if (fin_go) begin
      out_status_r <= res_status;
      out_fp_r     <= res_fp;
      out_hits_r   <= res_hits;
    end
  end

endmodule
